// File: rtl/core/dictionary_index_encoder_top_macros.svh
// Assertion macros for the dictionary index encoder top.
`ifndef DICTIONARY_INDEX_ENCODER_TOP_MACROS_SVH
`define DICTIONARY_INDEX_ENCODER_TOP_MACROS_SVH

// Check a condition on every clock edge outside reset.
`define DIE_ASSERT_NOW(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that a condition in one cycle implies another in the next.
`define DIE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/die_pkg.sv
// Shared constants and the token type for the dictionary index encoder.
package die_pkg;

  localparam int DICT_DEPTH = 256;
  localparam int WORD_W     = 32;
  localparam int IDX_W      = 8;
  localparam int CNT_W      = 9;

  localparam int S_TDATA_W  = 32;
  localparam int M_TDATA_W  = 24;

  localparam int M_IDX_LSB  = 0;
  localparam int M_NEW_BIT  = 8;
  localparam int M_OVF_BIT  = 9;
  localparam int M_CNT_LSB  = 10;

  typedef struct packed {
    logic              vld;
    logic [WORD_W-1:0] word;
    logic              last;
    logic              hit;
    logic              fresh;
    logic [IDX_W-1:0]  index;
    logic [CNT_W-1:0]  count;
  } die_token_t;

endpackage

// File: rtl/core/die_cell.sv
// One dictionary entry with its stage of the search token chain.
module die_cell
  import die_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  logic [IDX_W-1:0] cell_index,
  input  die_token_t       tok_in,
  output die_token_t       tok_out
);

  logic              ent_vld;
  logic [WORD_W-1:0] ent_val;
  logic              match;
  logic              place;
  die_token_t        tok_next;

  always_comb begin
    match = ent_vld && (ent_val == tok_in.word) && !tok_in.hit;
    place = !ent_vld && !tok_in.hit;
    tok_next       = tok_in;
    tok_next.hit   = tok_in.hit | match | place;
    tok_next.fresh = tok_in.fresh | place;
    tok_next.index = (match || place) ? cell_index : tok_in.index;
    tok_next.count = tok_in.count + CNT_W'(ent_vld | place);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_vld     <= 1'b0;
      tok_out.vld <= 1'b0;
    end else if (adv) begin
      tok_out.vld <= tok_in.vld;
      if (tok_in.vld) begin
        if (tok_in.last) begin
          ent_vld <= 1'b0;
        end else if (place) begin
          ent_vld <= 1'b1;
        end
      end
    end
    if (adv) begin
      tok_out.word  <= tok_next.word;
      tok_out.last  <= tok_next.last;
      tok_out.hit   <= tok_next.hit;
      tok_out.fresh <= tok_next.fresh;
      tok_out.index <= tok_next.index;
      tok_out.count <= tok_next.count;
      if (tok_in.vld && place) begin
        ent_val <= tok_in.word;
      end
    end
  end

endmodule

// File: rtl/core/dictionary_index_encoder_top.sv
// Dictionary index encoder: accepts one word per cycle while not stalled and returns its
// dictionary index, new-entry and overflow flags and the unique count. Each word travels
// down a chain of 256 entry cells, one cell per cycle, matching the stored value or taking
// the first free cell, while a new word can enter every cycle; the chain stalls as a whole
// while the output register holds an item that is not taken. A word marked last clears
// each cell as it passes.
module dictionary_index_encoder_top
  import die_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // [31:0] word_value
  input  logic                 s_tlast,   // last_of_block
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // [7:0] dict_index, [8] new_entry,
                                          // [9] overflow, [18:10] unique_count, [23:19] 0
  output logic                 m_tlast    // block_end
);

  `include "dictionary_index_encoder_top_macros.svh"

  logic                 adv;
  die_token_t           chain [0:DICT_DEPTH];
  logic [M_TDATA_W-1:0] m_tdata_next;
  logic                 out_new;
  logic                 out_ovf;
  logic                 out_full;
  logic                 out_zero_idx;
  logic                 out_stall;

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  always_comb begin
    chain[0]       = '0;
    chain[0].vld   = s_tvalid;
    chain[0].word  = s_tdata[WORD_W-1:0];
    chain[0].last  = s_tlast;
  end

  for (genvar k = 0; k < DICT_DEPTH; k++) begin : g_cell
    die_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .adv        (adv),
      .cell_index (IDX_W'(k)),
      .tok_in     (chain[k]),
      .tok_out    (chain[k+1])
    );
  end

  always_comb begin
    m_tdata_next                     = '0;
    m_tdata_next[M_IDX_LSB +: IDX_W] = chain[DICT_DEPTH].hit ? chain[DICT_DEPTH].index : '0;
    m_tdata_next[M_NEW_BIT]          = chain[DICT_DEPTH].fresh;
    m_tdata_next[M_OVF_BIT]          = !chain[DICT_DEPTH].hit;
    m_tdata_next[M_CNT_LSB +: CNT_W] = chain[DICT_DEPTH].count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= chain[DICT_DEPTH].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= m_tdata_next;
      m_tlast <= chain[DICT_DEPTH].last;
    end
  end

  assign out_new      = m_tvalid && m_tdata[M_NEW_BIT];
  assign out_ovf      = m_tvalid && m_tdata[M_OVF_BIT];
  assign out_full     = (m_tdata[M_CNT_LSB +: CNT_W] == CNT_W'(DICT_DEPTH));
  assign out_zero_idx = (m_tdata[M_IDX_LSB +: IDX_W] == '0);
  assign out_stall    = m_tvalid && !m_tready;

  `DIE_ASSERT_NOW(a_new_not_ovf, !(out_new && out_ovf), "new entry and overflow together")
  `DIE_ASSERT_NOW(a_ovf_full, !out_ovf || out_full, "overflow without full dictionary")
  `DIE_ASSERT_NOW(a_ovf_index, !out_ovf || out_zero_idx, "overflow with nonzero index")
  `DIE_ASSERT_NEXT(a_stall_hold, out_stall, $stable({m_tvalid, m_tdata, m_tlast}), "item not held")

endmodule

// File: verif/dictionary_index_encoder_top_tb.sv
// Testbench for the dictionary index encoder: directed and random streams checked against a predictor.
`timescale 1ns / 100ps

module dictionary_index_encoder_top_tb;
  import die_pkg::*;

  localparam int ITEM_TARGET = 2000;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int LONG_HOLD   = 800;
  localparam int DRAIN_WAIT  = 300;
  localparam int DIR_N       = 14;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             fresh;
    logic             ovf;
    logic [CNT_W-1:0] cnt;
    logic             blk_end;
  } enc_result_t;

  typedef struct {
    logic [WORD_W-1:0] w;
    logic              lst;
    bit                typed;
    logic [IDX_W-1:0]  idx;
    logic              fresh;
    logic              ovf;
    logic [CNT_W-1:0]  cnt;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic                 s_tlast = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tlast;

  logic [WORD_W-1:0] dict_words [DICT_DEPTH];
  int                dict_fill;
  enc_result_t       pending_encodings [$];
  int                mismatches;
  int                sent_items;
  int                cycle_count;
  int                hold_reqs;
  int                hold_served;
  int                stall_left;
  bit                tx_burst;
  bit                rx_burst;
  bit                force_full;

  dir_row_t dir_rows [DIR_N] = '{
    '{32'h0000_0000, 1'b0, 1'b1, 8'd0, 1'b1, 1'b0, 9'd1},
    '{32'hFFFF_FFFF, 1'b0, 1'b1, 8'd1, 1'b1, 1'b0, 9'd2},
    '{32'h0000_0000, 1'b0, 1'b1, 8'd0, 1'b0, 1'b0, 9'd2},
    '{32'hFFFF_FFFF, 1'b1, 1'b1, 8'd1, 1'b0, 1'b0, 9'd2},
    '{32'hFFFF_FFFF, 1'b1, 1'b1, 8'd0, 1'b1, 1'b0, 9'd1},
    '{32'h8000_0000, 1'b0, 1'b1, 8'd0, 1'b1, 1'b0, 9'd1},
    '{32'h0000_0001, 1'b0, 1'b1, 8'd1, 1'b1, 1'b0, 9'd2},
    '{32'h8000_0000, 1'b0, 1'b1, 8'd0, 1'b0, 1'b0, 9'd2},
    '{32'h7FFF_FFFF, 1'b1, 1'b1, 8'd2, 1'b1, 1'b0, 9'd3},
    '{32'h1234_5678, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0, 9'd0},
    '{32'h1234_5678, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0, 9'd0},
    '{32'hA5A5_A5A5, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0, 9'd0},
    '{32'h5A5A_5A5A, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0, 9'd0},
    '{32'h1234_5678, 1'b1, 1'b0, 8'd0, 1'b0, 1'b0, 9'd0}
  };

  dictionary_index_encoder_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  function automatic enc_result_t encode_word(logic [WORD_W-1:0] w, logic lst);
    enc_result_t r;
    bit          hit;
    r   = '0;
    hit = 1'b0;
    for (int k = 0; k < dict_fill; k++) begin
      if (!hit && dict_words[k] == w) begin
        hit   = 1'b1;
        r.idx = IDX_W'(k);
      end
    end
    if (!hit) begin
      if (dict_fill < DICT_DEPTH) begin
        dict_words[dict_fill] = w;
        r.idx   = IDX_W'(dict_fill);
        r.fresh = 1'b1;
        dict_fill++;
      end else begin
        r.ovf = 1'b1;
      end
    end
    r.cnt     = CNT_W'(dict_fill);
    r.blk_end = lst;
    if (lst) dict_fill = 0;
    return r;
  endfunction

  task automatic send_word(logic [WORD_W-1:0] w, logic lst, bit typed, enc_result_t typed_res);
    int          gap;
    int          pick;
    enc_result_t predicted;
    gap  = 0;
    pick = $urandom_range(0, 99);
    if (!tx_burst) begin
      if (pick >= 95) gap = $urandom_range(10, 40);
      else if (pick >= 65) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= w;
    s_tlast  <= lst;
    do @(posedge clk); while (!s_tready);
    predicted = encode_word(w, lst);
    pending_encodings.push_back(typed ? typed_res : predicted);
    sent_items++;
  endtask

  task automatic send_block();
    int                kind;
    int                len;
    int                mode;
    int                fresh_sent;
    int                tail;
    bit                open_end;
    logic              lst;
    logic [WORD_W-1:0] base;
    logic [WORD_W-1:0] w;
    kind     = $urandom_range(0, 99);
    base     = $urandom;
    tx_burst = ($urandom_range(0, 3) == 0);
    if (force_full || kind < 12) begin
      force_full = 1'b0;
      fresh_sent = 0;
      tail       = $urandom_range(1, 40);
      while (fresh_sent < DICT_DEPTH || tail > 0) begin
        if (fresh_sent >= DICT_DEPTH) tail--;
        if (fresh_sent > 0 && $urandom_range(0, 3) == 0) begin
          w = base ^ WORD_W'($urandom_range(0, fresh_sent - 1));
        end else begin
          w = base ^ WORD_W'(fresh_sent);
          fresh_sent++;
        end
        lst = (fresh_sent >= DICT_DEPTH && tail == 0);
        send_word(w, lst, 1'b0, '0);
      end
    end else begin
      len      = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 20);
      mode     = $urandom_range(0, 2);
      open_end = ($urandom_range(0, 9) == 0);
      for (int i = 0; i < len; i++) begin
        case (mode)
          0: w = WORD_W'($urandom_range(0, 7));
          1: w = $urandom;
          default: w = base ^ WORD_W'($urandom_range(0, 15));
        endcase
        lst = (i == len - 1 && !open_end) || ($urandom_range(0, 29) == 0);
        send_word(w, lst, 1'b0, '0);
      end
    end
  endtask

  initial begin
    dict_fill   = 0;
    mismatches  = 0;
    sent_items  = 0;
    hold_reqs   = 0;
    tx_burst    = 1'b0;
    force_full  = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < DIR_N; i++) begin
      send_word(dir_rows[i].w, dir_rows[i].lst, dir_rows[i].typed,
                '{dir_rows[i].idx, dir_rows[i].fresh, dir_rows[i].ovf,
                  dir_rows[i].cnt, dir_rows[i].lst});
    end
    hold_reqs++;
    while (sent_items < ITEM_TARGET) send_block();
    s_tvalid <= 1'b0;
    while (pending_encodings.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("dictionary_index_encoder_top_tb OK");
    end else begin
      $display("dictionary_index_encoder_top_tb NOT OK");
    end
    $finish;
  end

  initial begin
    hold_served = 0;
    stall_left  = 0;
    rx_burst    = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (hold_served != hold_reqs) begin
        hold_served = hold_reqs;
        stall_left  = LONG_HOLD;
      end
      if ($urandom_range(0, 199) == 0) rx_burst = !rx_burst;
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (rx_burst) begin
        m_tready <= 1'b1;
      end else begin
        case ($urandom_range(0, 99)) inside
          [0:59]: m_tready <= 1'b1;
          [60:94]: begin
            m_tready <= 1'b0;
            stall_left = $urandom_range(0, 3);
          end
          default: begin
            m_tready <= 1'b0;
            stall_left = $urandom_range(10, 60);
          end
        endcase
      end
    end
  end

  always @(posedge clk) begin
    enc_result_t got;
    enc_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.idx     = m_tdata[M_IDX_LSB +: IDX_W];
      got.fresh   = m_tdata[M_NEW_BIT];
      got.ovf     = m_tdata[M_OVF_BIT];
      got.cnt     = m_tdata[M_CNT_LSB +: CNT_W];
      got.blk_end = m_tlast;
      if (pending_encodings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected item: idx=%0d new=%0b ovf=%0b cnt=%0d end=%0b",
                   got.idx, got.fresh, got.ovf, got.cnt, got.blk_end);
      end else begin
        want = pending_encodings.pop_front();
        if (got.idx !== want.idx || got.fresh !== want.fresh || got.ovf !== want.ovf ||
            got.cnt !== want.cnt || got.blk_end !== want.blk_end) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp idx=%0d new=%0b ovf=%0b cnt=%0d end=%0b, got idx=%0d new=%0b ovf=%0b cnt=%0d end=%0b",
                     want.idx, want.fresh, want.ovf, want.cnt, want.blk_end,
                     got.idx, got.fresh, got.ovf, got.cnt, got.blk_end);
        end
      end
    end
  end

  initial cycle_count = 0;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("dictionary_index_encoder_top_tb NOT OK");
      $finish;
    end
  end

endmodule

// File: dictionary_index_encoder_top.f
+incdir+rtl/core
rtl/core/die_pkg.sv
rtl/core/die_cell.sv
rtl/core/dictionary_index_encoder_top.sv
verif/dictionary_index_encoder_top_tb.sv
